// ----- hw/rtl/my86_pkg.sv -----
// Package for the mini Y86 execute unit: sizes, instruction codes and flag helpers.
`timescale 1ns / 1ps
package my86_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned MemWords = 16;

  localparam int unsigned RegIdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int unsigned MemIdxW = (MemWords > 1) ? $clog2(MemWords) : 1;

  localparam int unsigned ModeW  = 4;
  localparam int unsigned RegSelW = 4;
  localparam int unsigned WordW  = 32;

  // Overflow window for OF: result must lie in -128..127
  localparam int unsigned OfKeepW = 7;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [ModeW-1:0] {
    OpAdd   = 4'd0,
    OpSub   = 4'd1,
    OpCmp   = 4'd2,
    OpRrmov = 4'd3,
    OpIrmov = 4'd4,
    OpRmmov = 4'd5,
    OpMrmov = 4'd6,
    OpJe    = 4'd7,
    OpJne   = 4'd8,
    OpJg    = 4'd9,
    OpJl    = 4'd10
  } mode_e;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } cc_t;

  function automatic cc_t codes_of(word_t r);
    cc_t c;
    c.zf = (r == '0);
    c.sf = r[WordW-1];
    c.of = !((r[WordW-1:OfKeepW] == '0) || (r[WordW-1:OfKeepW] == '1));
    return c;
  endfunction

endpackage

// ----- hw/rtl/mini_y86_execute_unit.sv -----
// Top level of the mini Y86 execute unit: operand fetch, execute and result register.
`timescale 1ns / 1ps
// An accepted input passes through the operand register and then the result register before its result is valid.
// Throughput: one transaction per cycle; the operand stage advances whenever the result
//   register is empty or being drained, and register reads bypass the write in flight.
// Reset: rst_ni clears the pipeline valids, the condition codes, the register file valid
//   bits (unwritten registers read as zero) and the data memory words.
module mini_y86_execute_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [my86_pkg::ModeW-1:0]      mode_i,
  input  logic [my86_pkg::RegSelW-1:0]    src_reg_i,
  input  logic [my86_pkg::RegSelW-1:0]    dst_reg_i,
  input  logic signed [my86_pkg::WordW-1:0] immediate_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [my86_pkg::WordW-1:0] write_value_o,
  output logic                            zero_flag_o,
  output logic                            sign_flag_o,
  output logic                            overflow_flag_o,
  output logic                            branch_taken_o,
  output logic                            address_fault_o
);
  import my86_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  word_t               rf_q [NumRegs];   // register file storage, no reset
  logic [NumRegs-1:0]  rf_vld_q;         // invalid entry reads as zero
  word_t               dm_q [MemWords];  // data memory, small enough for flops
  cc_t                 cc_q, cc_d;

  // Operand stage
  logic                  a_vld_q;
  logic [ModeW-1:0]      a_mode_q;
  logic [RegSelW-1:0]    a_ra_q, a_rb_q;
  word_t                 a_imm_q;
  word_t                 a_va_q, a_vb_q;

  // Result stage
  logic                  r_vld_q;
  word_t                 r_wv_q, r_wv_d;
  cc_t                   r_cc_q;
  logic                  r_taken_q, r_taken_d;
  logic                  r_fault_q, r_fault_d;

  // Handshake
  logic fire;       // operand stage moves into result register
  logic in_acc;

  assign fire       = a_vld_q && (!r_vld_q || out_ready_i);
  assign in_ready_o = !a_vld_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------
  logic                 wr_en;
  logic [RegSelW-1:0]   wr_idx;
  word_t                wr_data;
  logic                 st_en;
  word_t                addr;
  logic                 addr_ok;
  logic [MemIdxW-1:0]   slot;
  word_t                sum, diff;

  assign sum     = a_vb_q + a_va_q;
  assign diff    = a_vb_q - a_va_q;
  assign addr    = a_vb_q + a_imm_q;
  // Unsigned compare also rejects negative addresses (sign bit set)
  assign addr_ok = (addr < WordW'(MemWords));
  assign slot    = addr[MemIdxW-1:0];

  always_comb begin
    r_wv_d    = '0;
    r_taken_d = 1'b0;
    r_fault_d = 1'b0;
    cc_d      = cc_q;
    wr_en     = 1'b0;
    wr_idx    = a_rb_q;
    wr_data   = '0;
    st_en     = 1'b0;
    case (mode_e'(a_mode_q))
      OpAdd: begin
        r_wv_d = sum;
        cc_d   = codes_of(sum);
        wr_en  = 1'b1;
      end
      OpSub: begin
        r_wv_d = diff;
        cc_d   = codes_of(diff);
        wr_en  = 1'b1;
      end
      OpCmp: begin
        r_wv_d = diff;
        cc_d   = codes_of(diff);
      end
      OpRrmov: begin
        r_wv_d = a_va_q;
        wr_en  = 1'b1;
      end
      OpIrmov: begin
        r_wv_d = a_imm_q;
        wr_en  = 1'b1;
      end
      OpRmmov: begin
        if (addr_ok) begin
          r_wv_d = a_va_q;
          st_en  = 1'b1;
        end else begin
          r_fault_d = 1'b1;
        end
      end
      OpMrmov: begin
        wr_idx = a_ra_q;
        if (addr_ok) begin
          r_wv_d = dm_q[slot];
          wr_en  = 1'b1;
        end else begin
          r_fault_d = 1'b1;
        end
      end
      OpJe:  r_taken_d = cc_q.zf;
      OpJne: r_taken_d = !cc_q.zf;
      OpJg:  r_taken_d = !(cc_q.sf ^ cc_q.of) && !cc_q.zf;
      OpJl:  r_taken_d = cc_q.sf ^ cc_q.of;
      default: begin
        // unused opcodes: no state change, zero result
        r_wv_d = '0;
      end
    endcase
    wr_data = r_wv_d;
    // Writes to a register index past the file are dropped
    wr_en   = wr_en && fire && ({1'b0, wr_idx} < (RegSelW + 1)'(NumRegs));
    st_en   = st_en && fire;
  end

  // ---------------------------------------------------------------------------
  // Register file: write port from execute, two read ports into operand stage.
  // Reads bypass the same-cycle write so back-to-back dependents see it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_q[wr_idx[RegIdxW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (wr_en) begin
      rf_vld_q[wr_idx[RegIdxW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_mode_q <= mode_i;
      a_ra_q   <= src_reg_i;
      a_rb_q   <= dst_reg_i;
      a_imm_q  <= word_t'(immediate_i);
      if ({1'b0, src_reg_i} >= (RegSelW + 1)'(NumRegs)) begin
        a_va_q <= '0;
      end else if (wr_en && (wr_idx == src_reg_i)) begin
        a_va_q <= wr_data;
      end else if (rf_vld_q[src_reg_i[RegIdxW-1:0]]) begin
        a_va_q <= rf_q[src_reg_i[RegIdxW-1:0]];
      end else begin
        a_va_q <= '0;
      end
      if ({1'b0, dst_reg_i} >= (RegSelW + 1)'(NumRegs)) begin
        a_vb_q <= '0;
      end else if (wr_en && (wr_idx == dst_reg_i)) begin
        a_vb_q <= wr_data;
      end else if (rf_vld_q[dst_reg_i[RegIdxW-1:0]]) begin
        a_vb_q <= rf_q[dst_reg_i[RegIdxW-1:0]];
      end else begin
        a_vb_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Data memory and condition codes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MemWords; k++) begin
        dm_q[k] <= '0;
      end
    end else if (st_en) begin
      dm_q[slot] <= a_va_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= '0;
    end else if (fire) begin
      cc_q <= cc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline valids and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        a_vld_q <= 1'b1;
      end else if (fire) begin
        a_vld_q <= 1'b0;
      end
      if (fire) begin
        r_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        r_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_wv_q    <= r_wv_d;
      r_cc_q    <= cc_d;
      r_taken_q <= r_taken_d;
      r_fault_q <= r_fault_d;
    end
  end

  assign out_valid_o     = r_vld_q;
  assign write_value_o   = signed'(r_wv_q);
  assign zero_flag_o     = r_cc_q.zf;
  assign sign_flag_o     = r_cc_q.sf;
  assign overflow_flag_o = r_cc_q.of;
  assign branch_taken_o  = r_taken_q;
  assign address_fault_o = r_fault_q;

endmodule
